/* hdl/btwp_pkg.sv */
// ============================================================================
// Busy-time window profiler package
// Shared sizes, event and command codes, and the command record that travels
// from the front part through the queue to the back part.
// ============================================================================
package btwp_pkg;

    // Frame slot ring.
    localparam int SLOTS      = 16;
    localparam int SLOT_IDX_W = $clog2(SLOTS);
    localparam int SLOT_W     = 40;
    localparam int SUM_W      = SLOT_W + $clog2(SLOTS);

    // Timestamps, configuration and result sizes.
    localparam int TICK_W     = 32;
    localparam int OVH_W      = 16;
    localparam int VAL_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Millisecond scaling: ticks * 1000 * 2^16 / rate.
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] MS_SCALE = 10'd1000;
    localparam int PROD_W  = SUM_W + SCALE_W;
    localparam int DVD_W   = PROD_W + FRAC_W;
    localparam int HI_W    = DVD_W - VAL_W;
    localparam int DIV_W   = TICK_W + $clog2(SLOTS);
    localparam int CNT_W   = $clog2(VAL_W + 1);

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 32'd1000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 4'd1;

    // Event kinds.
    localparam logic [2:0] KIND_MARK   = 3'd0;
    localparam logic [2:0] KIND_LAP    = 3'd1;
    localparam logic [2:0] KIND_BEGIN  = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // Result kinds.
    localparam logic RES_LAP     = 1'b0;
    localparam logic RES_AVERAGE = 1'b1;

    // Command queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] cmd_op_t;
    localparam cmd_op_t CMD_LAP   = 2'd0;
    localparam cmd_op_t CMD_ACCUM = 2'd1;
    localparam cmd_op_t CMD_READ  = 2'd2;

    // One unit of work for the back part.
    typedef struct packed {
        cmd_op_t                 op;
        logic                    add;
        logic                    first;
        logic                    warm;
        logic [SLOT_IDX_W-1:0]   acc_slot;
        logic [SLOT_IDX_W-1:0]   clr_slot;
        logic [TICK_W-1:0]       ticks;
    } cmd_t;

endpackage

/* hdl/btwp_front.sv */
// ============================================================================
// Busy-time window profiler front part
// Accepts events, keeps the reference time, block and ring bookkeeping, and
// turns laps, block ends and frame reads into commands for the back part.
// ============================================================================
module btwp_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         event_valid,
    output logic                         event_stall,
    input  logic [2:0]                   kind,
    input  logic [btwp_pkg::TICK_W-1:0]  timestamp,
    input  logic [btwp_pkg::OVH_W-1:0]   overhead_ticks,
    input  logic                         queue_full,
    output logic                         push,
    output btwp_pkg::cmd_t               cmd
);
    import btwp_pkg::*;

    logic [TICK_W-1:0]     mark_time_reg,  mark_time_next;
    logic                  block_open_reg, block_open_next;
    logic [SLOT_IDX_W-1:0] slot_index_reg, slot_index_next;
    logic                  first_done_reg, first_done_next;
    logic                  wrapped_reg,    wrapped_next;

    logic                  accept;
    logic [TICK_W-1:0]     elapsed;
    logic [TICK_W-1:0]     ticks;
    logic [SLOT_IDX_W-1:0] next_slot;

    // The front part takes an event whenever the queue has room.
    assign event_stall = queue_full;
    assign accept      = event_valid && !queue_full;

    // Interval since the reference, less the overhead, floored at zero.
    assign elapsed = timestamp - mark_time_reg;
    assign ticks   = (elapsed > TICK_W'(overhead_ticks)) ?
                     (elapsed - TICK_W'(overhead_ticks)) : '0;

    assign next_slot = (slot_index_reg == SLOT_IDX_W'(SLOTS - 1)) ?
                       '0 : (slot_index_reg + 1'b1);

    // Event decoding and command building.
    always_comb
    begin
        mark_time_next  = mark_time_reg;
        block_open_next = block_open_reg;
        slot_index_next = slot_index_reg;
        first_done_next = first_done_reg;
        wrapped_next    = wrapped_reg;
        push            = 1'b0;
        cmd.op          = CMD_LAP;
        cmd.add         = 1'b0;
        cmd.first       = 1'b0;
        cmd.warm        = 1'b0;
        cmd.acc_slot    = slot_index_reg;
        cmd.clr_slot    = next_slot;
        cmd.ticks       = ticks;
        if (accept)
        begin
            unique case (kind)
                KIND_MARK:
                begin
                    mark_time_next = timestamp;
                end
                KIND_LAP:
                begin
                    mark_time_next = timestamp;
                    push           = 1'b1;
                end
                KIND_BEGIN:
                begin
                    if (!block_open_reg)
                    begin
                        mark_time_next  = timestamp;
                        block_open_next = 1'b1;
                    end
                end
                KIND_END:
                begin
                    if (block_open_reg)
                    begin
                        mark_time_next  = timestamp;
                        block_open_next = 1'b0;
                        cmd.op          = CMD_ACCUM;
                        push            = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    cmd.op  = CMD_READ;
                    cmd.add = block_open_reg;
                    push    = 1'b1;
                    if (block_open_reg)
                    begin
                        mark_time_next  = timestamp;
                        block_open_next = 1'b0;
                    end
                    if (!first_done_reg)
                    begin
                        // The first read only clears the current slot.
                        cmd.first       = 1'b1;
                        cmd.clr_slot    = slot_index_reg;
                        first_done_next = 1'b1;
                    end
                    else
                    begin
                        slot_index_next = next_slot;
                        cmd.warm        = !wrapped_reg && (next_slot != '0);
                        if (!wrapped_reg && (next_slot == '0))
                        begin
                            wrapped_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_time_reg  <= '0;
            block_open_reg <= 1'b0;
            slot_index_reg <= '0;
            first_done_reg <= 1'b0;
            wrapped_reg    <= 1'b0;
        end
        else
        begin
            mark_time_reg  <= mark_time_next;
            block_open_reg <= block_open_next;
            slot_index_reg <= slot_index_next;
            first_done_reg <= first_done_next;
            wrapped_reg    <= wrapped_next;
        end
    end

endmodule

/* hdl/btwp_queue.sv */
// ============================================================================
// Busy-time window profiler command queue
// A short first-in first-out store of commands that lets the front part keep
// taking events while the back part works through a division.
// ============================================================================
module btwp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  btwp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output btwp_pkg::cmd_t  head_cmd,
    output logic            not_empty
);
    import btwp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : (wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : (rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command popped from an empty queue");
`endif

endmodule

/* hdl/btwp_back.sv */
// ============================================================================
// Busy-time window profiler back part
// Runs commands: slot accumulation and clearing in the slot memory with a
// running window total, millisecond scaling, and a one bit per cycle divider
// feeding the result register.
// ============================================================================
module btwp_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  btwp_pkg::cmd_t                head_cmd,
    input  logic                          not_empty,
    output logic                          pop,
    input  logic [btwp_pkg::TICK_W-1:0]   tick_rate,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          result_kind,
    output logic [btwp_pkg::VAL_W-1:0]    time_value,
    output logic                          warming_up
);
    import btwp_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ACC_RD = 4'd1;
    localparam logic [3:0] ST_ACC_WR = 4'd2;
    localparam logic [3:0] ST_PREP   = 4'd3;
    localparam logic [3:0] ST_CLR_WR = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_CHK    = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};
    localparam logic [VAL_W-1:0]  VAL_MAX  = {VAL_W{1'b1}};

    logic [3:0]            state_reg, state_next;
    cmd_t                  cmd_reg;

    // Slot memory with per-entry valid bits; an invalid entry reads as zero.
    logic [SLOT_W-1:0]     slot_ticks_reg [SLOTS];
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [SLOT_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  wr_en;

    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [VAL_W-1:0]      lo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VAL_W-1:0]      res_value_reg;
    logic                  res_warm_reg;
    logic                  result_valid_reg;
    logic                  result_kind_reg;
    logic [VAL_W-1:0]      time_value_reg;
    logic                  warming_up_reg;

    logic [SLOT_W-1:0]     old_ticks;
    logic [SLOT_W:0]       acc_sum;
    logic [SLOT_W-1:0]     acc_new;
    logic [TICK_W-1:0]     rate_eff;
    logic [DIV_W-1:0]      lap_div;
    logic [DIV_W-1:0]      avg_div;
    logic [SUM_W-1:0]      mul_operand;
    logic [PROD_W-1:0]     product;
    logic [DVD_W-1:0]      dividend;
    logic [HI_W-1:0]       dvd_hi;
    logic                  quot_ovf;
    logic [DIV_W:0]        trial;
    logic [DIV_W:0]        trial_diff;
    logic                  trial_ge;
    logic [DIV_W-1:0]      rem_step;
    logic                  no_divide;
    logic                  out_load;

    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign out_load = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);

    // Read-modify-write of the current slot, saturating at the slot width.
    assign old_ticks = rd_valid_reg ? rd_data_reg : '0;
    assign acc_sum   = {1'b0, old_ticks} + (SLOT_W + 1)'(cmd_reg.ticks);
    assign acc_new   = acc_sum[SLOT_W] ? SLOT_MAX : acc_sum[SLOT_W-1:0];
    assign rd_addr   = (state_reg == ST_PREP) ? cmd_reg.clr_slot : cmd_reg.acc_slot;
    assign wr_en     = (state_reg == ST_ACC_WR);

    // A frame read with no average to give answers zero at once.
    assign no_divide = cmd_reg.first || cmd_reg.warm;

    // Scaling operands; a zero tick rate counts as one.
    assign rate_eff    = (tick_rate == '0) ? TICK_W'(1) : tick_rate;
    assign lap_div     = DIV_W'(rate_eff);
    assign avg_div     = DIV_W'(rate_eff) * DIV_W'(SLOTS);
    assign mul_operand = (cmd_reg.op == CMD_LAP) ? SUM_W'(cmd_reg.ticks) : sum_reg;
    assign product     = PROD_W'(mul_operand) * PROD_W'(MS_SCALE);

    // The quotient overflows the result width exactly when the upper part of
    // the dividend is not below the divisor.
    assign dividend = {prod_reg, {FRAC_W{1'b0}}};
    assign dvd_hi   = dividend[DVD_W-1:VAL_W];
    assign quot_ovf = (DIV_W'(dvd_hi) >= div_reg);

    // One restoring division step.
    assign trial      = {rem_reg, lo_reg[VAL_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign rem_step   = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    if (head_cmd.op == CMD_LAP)
                    begin
                        state_next = ST_MUL;
                    end
                    else if ((head_cmd.op == CMD_ACCUM) || head_cmd.add)
                    begin
                        state_next = ST_ACC_RD;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                state_next = (cmd_reg.op == CMD_READ) ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                state_next = no_divide ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next = quot_ovf ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, valid bits, window total and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_valid_reg   <= '0;
            rd_valid_reg     <= 1'b0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= slot_valid_reg[rd_addr];
            if (state_reg == ST_ACC_WR)
            begin
                slot_valid_reg[cmd_reg.acc_slot] <= 1'b1;
                total_reg <= total_reg + SUM_W'(acc_new) - SUM_W'(old_ticks);
            end
            else if (state_reg == ST_CLR_WR)
            begin
                slot_valid_reg[cmd_reg.clr_slot] <= 1'b0;
                total_reg <= total_reg - SUM_W'(old_ticks);
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Slot memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_ticks_reg[cmd_reg.acc_slot] <= acc_new;
        end
        rd_data_reg <= slot_ticks_reg[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (state_reg == ST_PREP)
        begin
            sum_reg <= total_reg;
        end
        if ((state_reg == ST_CLR_WR) && no_divide)
        begin
            res_value_reg <= '0;
            res_warm_reg  <= 1'b1;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= product;
            div_reg  <= (cmd_reg.op == CMD_LAP) ? lap_div : avg_div;
        end
        if (state_reg == ST_CHK)
        begin
            rem_reg       <= DIV_W'(dvd_hi);
            lo_reg        <= dividend[VAL_W-1:0];
            cnt_reg       <= CNT_W'(VAL_W);
            res_value_reg <= VAL_MAX;
            res_warm_reg  <= 1'b0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_step;
            lo_reg  <= {lo_reg[VAL_W-2:0], trial_ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                res_value_reg <= {lo_reg[VAL_W-2:0], trial_ge};
            end
        end
        if (out_load)
        begin
            result_kind_reg <= (cmd_reg.op == CMD_LAP) ? RES_LAP : RES_AVERAGE;
            time_value_reg  <= res_value_reg;
            warming_up_reg  <= res_warm_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign time_value   = time_value_reg;
    assign warming_up   = warming_up_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("division remainder reached the divisor");

    a_div_ends_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg == CNT_W'(1))) |=> (state_reg == ST_EMIT))
        else $error("division did not finish after its last step");
`endif

endmodule

/* hdl/busy_time_window_profiler_unit.sv */
// ============================================================================
// Busy-time window profiler
// Lap timing and a sixteen-frame average of busy time, reported in Q32.16
// milliseconds from timestamped events.
// ============================================================================
// Events enter a front part that takes one event per cycle while its
// four-entry command queue has room; marks, block begins and ignored events
// finish there in that cycle. Block ends cost the back part a slot read and
// write. A lap goes through the scaling multiply, an overflow check and the
// one bit per cycle divider, which runs 48 steps; a frame read first takes
// the window total and clears a slot, after adding any block that it
// closes. Warm-up reads and saturating results skip the division. A finished
// result waits in the output register while later events are queued.
// Configuration writes are always ready.
module busy_time_window_profiler_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             event_valid,
    output logic                             event_stall,
    input  logic [2:0]                       kind,
    input  logic [btwp_pkg::TICK_W-1:0]      timestamp,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             result_kind,
    output logic [btwp_pkg::VAL_W-1:0]       time_value,
    output logic                             warming_up,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btwp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btwp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import btwp_pkg::*;

    logic [OVH_W-1:0]  overhead_reg;
    logic [TICK_W-1:0] tick_rate_reg;
    logic              queue_full;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    cmd_t              head_cmd;
    logic              not_empty;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overhead_reg  <= '0;
            tick_rate_reg <= TICK_RATE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OVERHEAD:  overhead_reg  <= cfg_data[OVH_W-1:0];
                REG_TICK_RATE: tick_rate_reg <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Event classification.
    btwp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .event_valid    (event_valid),
        .event_stall    (event_stall),
        .kind           (kind),
        .timestamp      (timestamp),
        .overhead_ticks (overhead_reg),
        .queue_full     (queue_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    // Command queue between the two parts.
    btwp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty)
    );

    // Slot bookkeeping, scaling and division.
    btwp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .not_empty    (not_empty),
        .pop          (pop),
        .tick_rate    (tick_rate_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .time_value   (time_value),
        .warming_up   (warming_up)
    );

endmodule

/* tb/busy_time_window_profiler_checker.sv */
// ============================================================================
// Busy-time window profiler checker
// Watches the event, result and configuration channels of the profiler. It
// keeps its own copy of the profiler state, predicts the result of every
// accepted lap and frame read and compares each accepted result beat,
// field by field, with the oldest prediction still waiting.
// ============================================================================
module busy_time_window_profiler_checker
    import btwp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  event_valid,
    input  logic                  event_stall,
    input  logic [2:0]            kind,
    input  logic [TICK_W-1:0]     timestamp,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  logic                  result_kind,
    input  logic [VAL_W-1:0]      time_value,
    input  logic                  warming_up,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One millisecond in Q32.16 per second of ticks: 1000 * 2^16.
    localparam logic [127:0] MS_Q16_SCALE = 128'd65536000;

    typedef struct packed {
        logic             is_average;
        logic [VAL_W-1:0] value;
        logic             warm;
    } report_t;

    report_t               awaited_reports[$];
    logic [OVH_W-1:0]      overhead_now;
    logic [TICK_W-1:0]     rate_now;
    logic [TICK_W-1:0]     anchor_ts;
    logic                  busy_open;
    logic [SLOT_W-1:0]     frame_ticks [SLOTS];
    logic [SLOT_IDX_W-1:0] frame_ptr;
    logic                  primed;
    logic                  ring_full;
    int                    fail_count = 0;

    // Scales a tick count to Q32.16 milliseconds, truncating and saturating.
    function automatic logic [VAL_W-1:0] to_ms_q16(input logic [SUM_W-1:0] amount,
                                                   input logic [DIV_W-1:0] divisor);
        logic [127:0] quotient;
        quotient = (128'(amount) * MS_Q16_SCALE) / 128'(divisor);
        return (quotient[127:VAL_W] != '0) ? '1 : quotient[VAL_W-1:0];
    endfunction

    // A tick rate of zero counts as one.
    function automatic logic [DIV_W-1:0] rate_divisor();
        return (rate_now == '0) ? DIV_W'(1) : DIV_W'(rate_now);
    endfunction

    // Ticks since the anchor less the overhead; the event becomes the anchor.
    task automatic take_interval(input logic [TICK_W-1:0] stamp,
                                 output logic [TICK_W-1:0] ticks);
        logic [TICK_W-1:0] elapsed;
        elapsed   = stamp - anchor_ts;
        anchor_ts = stamp;
        ticks     = (elapsed > TICK_W'(overhead_now)) ? elapsed - TICK_W'(overhead_now) : '0;
    endtask

    // Closing an open block adds its busy time to the current slot.
    task automatic close_busy(input logic [TICK_W-1:0] stamp);
        logic [TICK_W-1:0] ticks;
        logic [SLOT_W:0]   grown;
        if (busy_open)
        begin
            take_interval(stamp, ticks);
            grown = {1'b0, frame_ticks[frame_ptr]} + (SLOT_W + 1)'(ticks);
            frame_ticks[frame_ptr] = grown[SLOT_W] ? '1 : grown[SLOT_W-1:0];
            busy_open = 1'b0;
        end
    endtask

    // Frame read: first read primes the ring, later reads advance, and average once the ring has filled.
    task automatic frame_read(input logic [TICK_W-1:0] stamp);
        logic [SUM_W-1:0] total;
        close_busy(stamp);
        if (!primed)
        begin
            frame_ticks[frame_ptr] = '0;
            primed = 1'b1;
            awaited_reports.push_back(report_t'{RES_AVERAGE, '0, 1'b1});
        end
        else
        begin
            frame_ptr = frame_ptr + 1'b1;
            total = '0;
            for (int i = 0; i < SLOTS; i++)
                total = total + SUM_W'(frame_ticks[i]);
            frame_ticks[frame_ptr] = '0;
            if (!ring_full && frame_ptr != '0)
            begin
                awaited_reports.push_back(report_t'{RES_AVERAGE, '0, 1'b1});
            end
            else
            begin
                ring_full = 1'b1;
                awaited_reports.push_back(report_t'{RES_AVERAGE,
                    to_ms_q16(total, DIV_W'(SLOTS) * rate_divisor()), 1'b0});
            end
        end
    endtask

    // Prediction on event beats, comparison on result beats.
    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        logic [TICK_W-1:0] ticks;
        report_t           want;
        if (!rst_n)
        begin
            overhead_now = '0;
            rate_now     = TICK_RATE_RESET;
            anchor_ts    = '0;
            busy_open    = 1'b0;
            frame_ptr    = '0;
            primed       = 1'b0;
            ring_full    = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                frame_ticks[i] = '0;
            awaited_reports.delete();
        end
        else
        begin
            // Register writes; unknown indexes have no effect.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OVERHEAD)
                    overhead_now = cfg_data[OVH_W-1:0];
                else if (cfg_index == REG_TICK_RATE)
                    rate_now = cfg_data;
            end

            // Event beats update the state and may add an expected report.
            if (event_valid && !event_stall)
            begin
                case (kind)
                    KIND_MARK:
                        anchor_ts = timestamp;
                    KIND_LAP:
                    begin
                        take_interval(timestamp, ticks);
                        awaited_reports.push_back(report_t'{RES_LAP,
                            to_ms_q16(SUM_W'(ticks), rate_divisor()), 1'b0});
                    end
                    KIND_BEGIN:
                        if (!busy_open)
                        begin
                            anchor_ts = timestamp;
                            busy_open = 1'b1;
                        end
                    KIND_END:
                        close_busy(timestamp);
                    KIND_READ:
                        frame_read(timestamp);
                    default:
                        ;
                endcase
            end

            // Result beats are matched against the oldest expected report.
            if (result_valid && !result_stall)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d, time_value 0x%0h, warming_up %0d",
                           result_kind, time_value, warming_up);
                    fail_count++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result_kind !== want.is_average)
                    begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.is_average, result_kind);
                        fail_count++;
                    end
                    if (time_value !== want.value)
                    begin
                        $error("time_value: expected 0x%0h, actual 0x%0h",
                               want.value, time_value);
                        fail_count++;
                    end
                    if (warming_up !== want.warm)
                    begin
                        $error("warming_up: expected %0d, actual %0d", want.warm, warming_up);
                        fail_count++;
                    end
                end
            end
        end
        failures    <= fail_count;
        outstanding <= awaited_reports.size();
    end

endmodule

/* tb/tb_busy_time_window_profiler_unit.sv */
// ============================================================================
// Busy-time window profiler testbench
// Drives timestamped events and register writes into the profiler with
// random gaps and stalls, including one long hold-off on the result side,
// and leaves all checking to the checker beside the block.
// ============================================================================
module tb_busy_time_window_profiler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import btwp_pkg::*;

    localparam int             WATCHDOG_LIMIT   = 5000;
    localparam int             HOLD_OFF_CYCLES  = 400;
    localparam int             HOLD_OFF_LAPS    = 12;
    localparam int             SETTLE_CYCLES    = 100;
    localparam int             TAIL_CYCLES      = 100;
    localparam int             PHASE_ITEMS      = 45;
    localparam int             SATURATING_PAIRS = 40;
    localparam int             PHASES           = 6;
    localparam logic [2:0]     KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0]     KIND_SPARE_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 4'd15;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  event_valid  = 1'b0;
    logic                  event_stall;
    logic [2:0]            kind         = KIND_MARK;
    logic [TICK_W-1:0]     timestamp    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  result_kind;
    logic [VAL_W-1:0]      time_value;
    logic                  warming_up;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_OVERHEAD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int                    chk_failures;
    int                    chk_outstanding;
    int                    send_idle_pct    = 9;
    int                    recv_idle_pct    = 60;
    logic                  hold_off_request = 1'b0;
    logic [TICK_W-1:0]     ts_now           = '0;
    logic                  progress;

    busy_time_window_profiler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .kind         (kind),
        .timestamp    (timestamp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .time_value   (time_value),
        .warming_up   (warming_up),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    busy_time_window_profiler_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .kind         (kind),
        .timestamp    (timestamp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .time_value   (time_value),
        .warming_up   (warming_up),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (chk_failures),
        .outstanding  (chk_outstanding)
    );

    // A beat of any kind counts as progress for the watchdog.
    assign progress = (event_valid && !event_stall) || (result_valid && !result_stall) ||
                      (cfg_valid && cfg_ready);

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, and one long hold-off when asked for.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                result_stall <= 1'b1;
                for (int held = 1; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any beat ends the run as a failure.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (progress)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one event beat after a random gap and holds it until accepted.
    task automatic send_event(input logic [2:0] code, input logic [TICK_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            event_valid <= 1'b0;
            @(posedge clk);
        end
        event_valid <= 1'b1;
        kind        <= code;
        timestamp   <= stamp;
        do
            @(posedge clk);
        while (event_stall);
    endtask

    // One register write beat; the caller lowers the valid after the group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Stops offering events and waits until every report is in and the block is quiet.
    task automatic settle();
        event_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Interval lengths: mostly short, some around the overhead range, a few anything.
    function automatic logic [TICK_W-1:0] pick_span();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return TICK_W'($urandom_range(2000));
        if (roll < 80)
            return TICK_W'($urandom_range(200000));
        if (roll < 92)
            return TICK_W'($urandom_range(70000));
        return $urandom;
    endfunction

    // Well-formed frames of busy blocks closed by a read, with some noise.
    task automatic play_frames(input int budget);
        int         counted;
        logic [2:0] code;
        counted = 0;
        while (counted < budget)
        begin
            if ($urandom_range(99) < 10)
            begin
                // Noise: any kind at any time, breaking brackets now and then.
                code = 3'($urandom_range(7));
                send_event(code, $urandom);
                if (code <= KIND_READ)
                    counted++;
            end
            else
            begin
                repeat ($urandom_range(3))
                begin
                    ts_now += pick_span();
                    send_event(KIND_BEGIN, ts_now);
                    if ($urandom_range(7) == 0)
                    begin
                        ts_now += pick_span();
                        send_event(KIND_LAP, ts_now);
                        counted++;
                    end
                    ts_now += pick_span();
                    send_event(KIND_END, ts_now);
                    counted += 2;
                end
                if ($urandom_range(2) == 0)
                begin
                    ts_now += pick_span();
                    send_event(KIND_MARK, ts_now);
                    ts_now += pick_span();
                    send_event(KIND_LAP, ts_now);
                    counted += 2;
                end
                // Sometimes the read itself has to close the block.
                if ($urandom_range(3) == 0)
                begin
                    ts_now += pick_span();
                    send_event(KIND_BEGIN, ts_now);
                    counted++;
                end
                ts_now += pick_span();
                send_event(KIND_READ, ts_now);
                counted++;
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] overhead_set [PHASES];
        logic [CFG_DATA_W-1:0] rate_set [PHASES];

        overhead_set[0] = '0;
        rate_set[0]     = CFG_DATA_W'(TICK_RATE_RESET);
        overhead_set[1] = 32'hABCD_FFFF;
        rate_set[1]     = 32'hFFFF_FFFF;
        overhead_set[2] = CFG_DATA_W'($urandom_range(255));
        rate_set[2]     = '0;
        overhead_set[3] = 32'd1000;
        rate_set[3]     = 32'd1;
        overhead_set[4] = CFG_DATA_W'($urandom_range(65535));
        rate_set[4]     = CFG_DATA_W'($urandom_range(1 << 20, 1));
        overhead_set[5] = '0;
        rate_set[5]     = 32'd3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Laps from the reset reference, across the counter wrap and at full range.
        send_event(KIND_LAP, 32'd0);
        send_event(KIND_MARK, 32'hFFFF_FFF0);
        send_event(KIND_LAP, 32'h0000_0010);
        send_event(KIND_LAP, 32'h0000_000F);

        // Unknown kinds and a block end with no block open are ignored.
        for (int code = int'(KIND_SPARE_FIRST); code <= int'(KIND_SPARE_LAST); code++)
            send_event(3'(code), $urandom);
        send_event(KIND_END, 32'd50);

        // A second begin while open leaves the reference alone.
        send_event(KIND_BEGIN, 32'd100);
        send_event(KIND_BEGIN, 32'd200);
        send_event(KIND_END, 32'd1100);

        // First read, then a read that closes an open block, then a plain read.
        send_event(KIND_READ, 32'd1200);
        send_event(KIND_BEGIN, 32'd5000);
        send_event(KIND_READ, 32'd7000);
        send_event(KIND_READ, 32'd8000);

        // One second at the reset tick rate, then an arbitrary lap.
        send_event(KIND_MARK, 32'd0);
        send_event(KIND_LAP, TICK_RATE_RESET);
        send_event(KIND_MARK, $urandom);
        send_event(KIND_LAP, $urandom);
        ts_now = 32'd8000;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = (phase < 2) ? 9 : (phase < 4) ? 60 : 0;
            recv_idle_pct = (phase < 2) ? 60 : (phase < 4) ? 9 : 0;

            // New register settings only while the block is idle.
            settle();
            write_reg(REG_OVERHEAD, overhead_set[phase]);
            write_reg(REG_TICK_RATE, rate_set[phase]);
            if (phase == 0)
            begin
                write_reg(REG_SPARE_TOP, $urandom);
                write_reg(CFG_IDX_W'($urandom_range(14, 2)), $urandom);
            end
            cfg_valid <= 1'b0;

            // The result side holds off while laps keep coming, so the input backs up.
            if (phase == 1)
            begin
                hold_off_request = 1'b1;
                repeat (HOLD_OFF_LAPS)
                begin
                    ts_now += pick_span();
                    send_event(KIND_LAP, ts_now);
                end
            end

            play_frames(PHASE_ITEMS);

            // One heavily loaded frame that drives the average into saturation,
            // then reads carry it round.
            if (phase == PHASES - 1)
            begin
                repeat (SATURATING_PAIRS)
                begin
                    send_event(KIND_BEGIN, ts_now);
                    ts_now += 32'hFFFF_FFFF - TICK_W'($urandom_range(32'h000F_FFFF));
                    send_event(KIND_END, ts_now);
                end
                send_event(KIND_READ, ts_now);
                play_frames(PHASE_ITEMS / 2);
            end
        end

        // Drain, let the block go quiet, then give the verdict.
        event_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (chk_failures == 0 && chk_outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
